FILE: src/touch_level_envelope_unit_macros.svh
// Assertion macros for the touch level envelope checker.
`ifndef TOUCH_LEVEL_ENVELOPE_UNIT_MACROS_SVH
`define TOUCH_LEVEL_ENVELOPE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("touch level envelope: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("touch level envelope: next-cycle check failed");

`endif

FILE: src/tle_pkg.sv
// Shared constants and codes for the touch level envelope unit.
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int READING_BITS = 16;
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int CH_W    = 2;
  localparam int LVL_W   = 16;
  localparam int CAL_W   = 48;
  localparam int CAL_NUM = 4;
  localparam int IDXR_W  = 3;
  localparam int CLS_W   = 2;

  localparam logic [LVL_W-1:0] RAW_MASK = LVL_W'((32'h1 << READING_BITS) - 1);
  localparam logic [LVL_W-1:0] FULL_LEVEL = 16'hFFFF;

  // Register indexes
  localparam logic [IDXR_W-1:0] REG_CAL0    = 3'd0;
  localparam logic [IDXR_W-1:0] REG_CAL1    = 3'd1;
  localparam logic [IDXR_W-1:0] REG_CAL2    = 3'd2;
  localparam logic [IDXR_W-1:0] REG_CAL3    = 3'd3;
  localparam logic [IDXR_W-1:0] REG_GATE    = 3'd4;
  localparam logic [IDXR_W-1:0] REG_TRIGGER = 3'd5;
  localparam logic [IDXR_W-1:0] REG_ATTACK  = 3'd6;
  localparam logic [IDXR_W-1:0] REG_RELEASE = 3'd7;

  // Register reset values
  localparam logic [CAL_W-1:0] CAL_RESET     = 48'd300650332175;
  localparam logic [LVL_W-1:0] GATE_RESET    = 16'd5243;
  localparam logic [LVL_W-1:0] TRIGGER_RESET = 16'd13107;
  localparam logic [LVL_W-1:0] ATTACK_RESET  = 16'd6554;
  localparam logic [LVL_W-1:0] RELEASE_RESET = 16'd655;

  // Contact class codes
  localparam logic [CLS_W-1:0] CLS_IDLE     = 2'd0;
  localparam logic [CLS_W-1:0] CLS_TOUCH    = 2'd1;
  localparam logic [CLS_W-1:0] CLS_BAREFOOT = 2'd2;
  localparam logic [CLS_W-1:0] CLS_UNUSED   = 2'd3;

  function automatic logic [LVL_W-1:0] abs_diff(input logic [LVL_W-1:0] a,
                                                input logic [LVL_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

FILE: src/touch_level_envelope_unit.sv
// Touch level envelope unit: reading to level, gate, trigger, envelope, class.
//
//  channel   dir  handshake          payload (low bit up)
//  s_*       in   s_tvalid/s_tready  tuser: channel[1:0]; tdata: raw_reading[15:0]
//  m_*       out  m_tvalid/m_tready  tuser: out_channel[1:0]; tdata: target_level,
//                                    envelope, note_trigger, contact_class, pad
//  cfg_*     in   cfg_we             cfg_index[2:0], cfg_data[47:0]
//
// A reading strictly between barefoot and idle passes from accept to the next
// ready through a load step, the shared restoring divider (one quotient bit
// a cycle, 16 quotient bits), a gate/multiply step and an update.
// Saturated readings skip the divider.
// rst (synchronous) restores register defaults and clears both channel stores.
// A result waiting in the output register does not block the next accept;
// only the update cycle holds while that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module touch_level_envelope_unit import tle_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [CH_W-1:0]   s_tuser,   // channel[1:0]
  input  wire logic [15:0]       s_tdata,   // raw_reading[15:0]
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [CH_W-1:0]        m_tuser,   // out_channel[1:0]
  output logic [39:0]            m_tdata,   // target_level[15:0], envelope[31:16],
                                            // note_trigger[32], contact_class[34:33]
  input  wire logic              cfg_we,
  input  wire logic [IDXR_W-1:0] cfg_index,
  input  wire logic [CAL_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_UPD
  } state_t;

  state_t state;

  // Configuration
  logic [CAL_W-1:0] cal [CAL_NUM];
  logic [LVL_W-1:0] gate_lvl;
  logic [LVL_W-1:0] trig_lvl;
  logic [LVL_W-1:0] attack_coef;
  logic [LVL_W-1:0] release_coef;

  // Per-channel state
  logic [LVL_W-1:0] env_store  [NUM_CHANNELS];
  logic [LVL_W-1:0] last_store [NUM_CHANNELS];

  // Working registers
  logic [CH_W-1:0]   ch;
  logic [LVL_W-1:0]  raw;
  logic [LVL_W-1:0]  rem;
  logic [LVL_W-1:0]  dvsr;
  logic [LVL_W-1:0]  quo;
  logic [3:0]        cnt;
  logic [LVL_W-1:0]  level;
  logic [CLS_W-1:0]  cls;
  logic              trig;
  logic              attack;
  logic [2*LVL_W-1:0] prod;
  logic [LVL_W-1:0]  env_old;

  // Comb helpers
  logic [IDX_W-1:0]  idx;
  logic [LVL_W-1:0]  cal_idle, cal_touch, cal_bare;
  logic [LVL_W-1:0]  d_idle, d_touch, d_bare;
  logic [CLS_W-1:0]  cls_next;
  logic [LVL_W:0]    rem_sh;
  logic              rem_ge;
  logic [LVL_W-1:0]  level_g;
  logic [LVL_W-1:0]  env_cur;
  logic              attack_next;
  logic [LVL_W-1:0]  diff_next;
  logic [LVL_W-1:0]  step;
  logic [LVL_W-1:0]  env_new;
  logic              out_free;
  logic              ch_ok;

  assign idx       = IDX_W'(ch);
  assign cal_idle  = cal[ch][47:32];
  assign cal_touch = cal[ch][31:16];
  assign cal_bare  = cal[ch][15:0];

  // Nearest calibration point; idle wins ties, then touch
  assign d_idle  = abs_diff(raw, cal_idle);
  assign d_touch = abs_diff(raw, cal_touch);
  assign d_bare  = abs_diff(raw, cal_bare);

  always_comb begin
    if (d_idle <= d_touch && d_idle <= d_bare) begin
      cls_next = CLS_IDLE;
    end else if (d_touch < d_idle && d_touch <= d_bare) begin
      cls_next = CLS_TOUCH;
    end else begin
      cls_next = CLS_BAREFOOT;
    end
  end

  // Shared divider step: shift one bit in, subtract when it fits
  assign rem_sh = {rem, 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, dvsr});

  // Gate and envelope direction
  assign level_g     = (level < gate_lvl) ? '0 : level;
  assign env_cur     = env_store[idx];
  assign attack_next = (level_g > env_cur);
  assign diff_next   = attack_next ? (level_g - env_cur) : (env_cur - level_g);

  assign step    = prod[2*LVL_W-1:LVL_W];
  assign env_new = attack ? (env_old + step) : (env_old - step);

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign ch_ok    = ({1'b0, s_tuser} < 3'(NUM_CHANNELS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < CAL_NUM; i++) begin
        cal[i] <= CAL_RESET;
      end
      gate_lvl     <= GATE_RESET;
      trig_lvl     <= TRIGGER_RESET;
      attack_coef  <= ATTACK_RESET;
      release_coef <= RELEASE_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        env_store[i]  <= '0;
        last_store[i] <= '0;
      end
    end else begin
      // Drop valid after the beat leaves, unless the update cycle refills it
      if (m_tvalid && m_tready && (state != ST_UPD)) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_CAL0:    cal[0]       <= cfg_data;
          REG_CAL1:    cal[1]       <= cfg_data;
          REG_CAL2:    cal[2]       <= cfg_data;
          REG_CAL3:    cal[3]       <= cfg_data;
          REG_GATE:    gate_lvl     <= cfg_data[LVL_W-1:0];
          REG_TRIGGER: trig_lvl     <= cfg_data[LVL_W-1:0];
          REG_ATTACK:  attack_coef  <= cfg_data[LVL_W-1:0];
          REG_RELEASE: release_coef <= cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          // Take a beat; drop it when the channel has no store
          if (s_tvalid && ch_ok) begin
            ch    <= s_tuser;
            raw   <= s_tdata & RAW_MASK;
            state <= ST_LOAD;
          end
        end

        ST_LOAD: begin
          cls <= cls_next;
          cnt <= '0;
          quo <= '0;
          if (raw <= cal_bare) begin
            level <= FULL_LEVEL;
            state <= ST_FIN;
          end else if (raw >= cal_idle) begin
            level <= '0;
            state <= ST_FIN;
          end else begin
            rem   <= cal_idle - raw;
            dvsr  <= cal_idle - cal_bare;
            state <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (rem_ge) begin
            rem <= LVL_W'(rem_sh - {1'b0, dvsr});
          end else begin
            rem <= rem_sh[LVL_W-1:0];
          end
          quo <= {quo[LVL_W-2:0], rem_ge};
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            level <= {quo[LVL_W-2:0], rem_ge};
            state <= ST_FIN;
          end
        end

        ST_FIN: begin
          level   <= level_g;
          trig    <= (level_g > trig_lvl) && (last_store[idx] <= trig_lvl);
          attack  <= attack_next;
          env_old <= env_cur;
          prod    <= {{LVL_W{1'b0}}, diff_next} *
                     {{LVL_W{1'b0}}, (attack_next ? attack_coef : release_coef)};
          state   <= ST_UPD;
        end

        ST_UPD: begin
          // Hold until the output register is free, then commit
          if (out_free) begin
            env_store[idx]  <= env_new;
            last_store[idx] <= level;
            m_tvalid        <= 1'b1;
            m_tuser         <= ch;
            m_tdata         <= {5'd0, cls, trig, env_new, level};
            state           <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/tle_checker.sv
// Port-level checker for the touch level envelope unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "touch_level_envelope_unit_macros.svh"

module tle_checker import tle_pkg::*; (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            s_tvalid,
  input wire logic            s_tready,
  input wire logic [CH_W-1:0] s_tuser,
  input wire logic            m_tvalid,
  input wire logic            m_tready,
  input wire logic [39:0]     m_tdata
);

  logic took_item;

  assign took_item = s_tvalid && s_tready && ({1'b0, s_tuser} < 3'(NUM_CHANNELS));

  // One item at a time: a kept beat closes the input for the next cycle
  `TLE_ASSERT_NEXT(a_busy_after_accept, took_item, !s_tready)

  // A stalled result holds
  `TLE_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // A zero level never fires a note
  `TLE_ASSERT_NOW(a_no_trigger_at_zero, m_tvalid && (m_tdata[15:0] == 16'd0), !m_tdata[32])

  // The spare class code never shows
  `TLE_ASSERT_NOW(a_class_code, m_tvalid, m_tdata[34:33] != CLS_UNUSED)

endmodule

bind touch_level_envelope_unit tle_checker u_tle_checker (.*);

`default_nettype wire
